### src/sbs_pkg.sv
// Stiff bar stencil package: shared types, codes and saturation helpers.
// Used by sbs_mac, the top level and the checker; depends on nothing.
package sbs_pkg;

   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 28;
   localparam int LANES    = 3;
   localparam int ROW_W    = LANES * DATA_W;
   localparam int MIN_LAST = 4;
   localparam int CSR_W    = 3;
   localparam int GRID_W   = 7;
   localparam int VIRT_W   = 36;

   localparam logic signed [VIRT_W-1:0] VIRT_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [VIRT_W-1:0] VIRT_MIN = 36'shF_8000_0000;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_EXCITE, ST_SWEEP, ST_PUT
   } state_type;

   // what the read issued last cycle is for
   typedef enum logic [2:0] {
      TAG_NONE, TAG_HEAD, TAG_REAL, TAG_VL2, TAG_VL1, TAG_VR1, TAG_VR2
   } tag_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_COEF_CENTER      = 3'd0,
      CSR_COEF_NEAR        = 3'd1,
      CSR_COEF_FAR         = 3'd2,
      CSR_COEF_PREV_CENTER = 3'd3,
      CSR_COEF_PREV_NEAR   = 3'd4,
      CSR_GRID_LAST        = 3'd5,
      CSR_LISTEN_INDEX     = 3'd6
   } csr_type;

   // control that travels with one grid point through the MAC pipe
   typedef struct packed {
      logic valid;
      logic listen;
      logic last;
   } pt_ctl_type;

   function automatic word_type sat_word(input logic signed [VIRT_W-1:0] x);
      if (x > VIRT_MAX) return word_type'(VIRT_MAX);
      else if (x < VIRT_MIN) return word_type'(VIRT_MIN);
      else return word_type'(x);
   endfunction

   function automatic logic sat_hit(input logic signed [VIRT_W-1:0] x);
      return (x > VIRT_MAX) || (x < VIRT_MIN);
   endfunction

   // 2a - b
   function automatic logic signed [VIRT_W-1:0] lin_ext(input word_type a,
                                                        input word_type b);
      return (VIRT_W'(a) <<< 1) - VIRT_W'(b);
   endfunction

   // 4(a - b) + c
   function automatic logic signed [VIRT_W-1:0] quad_ext(input word_type a,
                                                         input word_type b,
                                                         input word_type c);
      return ((VIRT_W'(a) - VIRT_W'(b)) <<< 2) + VIRT_W'(c);
   endfunction

endpackage

### src/sbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/sbs_mac.sv
// Eight-tap multiply-accumulate pipe: products, adder tree, round, saturate.
// Depends on sbs_pkg.
module sbs_mac #(
   parameter int PT_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  sbs_pkg::pt_ctl_type in_ctl,
   input  logic [PT_W-1:0]     in_pt,
   input  sbs_pkg::word_type   cur_tap [5],
   input  sbs_pkg::word_type   prv_tap [3],
   input  sbs_pkg::word_type   coef_center,
   input  sbs_pkg::word_type   coef_near,
   input  sbs_pkg::word_type   coef_far,
   input  sbs_pkg::word_type   coef_prev_center,
   input  sbs_pkg::word_type   coef_prev_near,
   output sbs_pkg::pt_ctl_type res_ctl,
   output logic [PT_W-1:0]     res_pt,
   output sbs_pkg::word_type   res_value,
   output logic                res_sat,
   output sbs_pkg::word_type   res_cur,
   output sbs_pkg::word_type   res_prv
);
   import sbs_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam int S1_W   = PROD_W + 1;
   localparam int S2_W   = PROD_W + 2;
   localparam int SUM_W  = PROD_W + 3;
   localparam int Q_W    = SUM_W - FRAC_W;
   localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(VIRT_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(VIRT_MIN);
   localparam int STAGES = 4;

   logic signed [PROD_W-1:0] prod_ff [8];
   logic signed [S1_W-1:0]   s1_ff [4];
   logic signed [S2_W-1:0]   s2_ff [2];
   logic signed [SUM_W-1:0]  s3_ff;
   pt_ctl_type               ctl_ff [STAGES];
   logic [PT_W-1:0]          pt_ff  [STAGES];
   word_type                 cv_ff  [STAGES];
   word_type                 pv_ff  [STAGES];
   logic signed [SUM_W-1:0]  rounded;
   logic signed [Q_W-1:0]    quot;

   // products, one register each
   always_ff @(posedge clock) begin
      prod_ff[0] <= PROD_W'(coef_center)      * PROD_W'(cur_tap[2]);
      prod_ff[1] <= PROD_W'(coef_near)        * PROD_W'(cur_tap[3]);
      prod_ff[2] <= PROD_W'(coef_near)        * PROD_W'(cur_tap[1]);
      prod_ff[3] <= PROD_W'(coef_far)         * PROD_W'(cur_tap[4]);
      prod_ff[4] <= PROD_W'(coef_far)         * PROD_W'(cur_tap[0]);
      prod_ff[5] <= PROD_W'(coef_prev_center) * PROD_W'(prv_tap[1]);
      prod_ff[6] <= PROD_W'(coef_prev_near)   * PROD_W'(prv_tap[2]);
      prod_ff[7] <= PROD_W'(coef_prev_near)   * PROD_W'(prv_tap[0]);
   end

   // registered adder tree, exact
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         s1_ff[i] <= S1_W'(prod_ff[2*i]) + S1_W'(prod_ff[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
         s2_ff[i] <= S2_W'(s1_ff[2*i]) + S2_W'(s1_ff[2*i+1]);
      end
      s3_ff <= SUM_W'(s2_ff[0]) + SUM_W'(s2_ff[1]);
   end

   // side data follows the sum
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) ctl_ff[i] <= '0;
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int i = 1; i < STAGES; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
      pt_ff[0] <= in_pt;
      cv_ff[0] <= cur_tap[2];
      pv_ff[0] <= prv_tap[1];
      for (int i = 1; i < STAGES; i++) begin
         pt_ff[i] <= pt_ff[i-1];
         cv_ff[i] <= cv_ff[i-1];
         pv_ff[i] <= pv_ff[i-1];
      end
   end

   // round half up to Q3.28, then saturate
   always_comb begin
      rounded = s3_ff + HALF_LSB;
      quot    = rounded[SUM_W-1:FRAC_W];
      res_sat = (quot > Q_MAX) || (quot < Q_MIN);
      if (quot > Q_MAX) res_value = word_type'(Q_MAX);
      else if (quot < Q_MIN) res_value = word_type'(Q_MIN);
      else res_value = word_type'(quot);
   end

   assign res_ctl = ctl_ff[STAGES-1];
   assign res_pt  = pt_ff[STAGES-1];
   assign res_cur = cv_ff[STAGES-1];
   assign res_prv = pv_ff[STAGES-1];
endmodule

### src/stiff_bar_free_end_stencil.sv
// Stiff bar with free ends: grid memory, sweep sequencer, stencil window.
// Depends on sbs_pkg, sbs_ram and sbs_mac.
//
//   channel | dir | handshake           | beat
//   req     | in  | req_valid/req_stall | kind, point_index, excite_amount
//   rsp     | out | rsp_valid/rsp_stall | displacement, saturated
//   csr     | in  | csr_valid/csr_ready | index, data
//
// A step for last grid point L sweeps rows 0 to L: the sweep reads one
// memory row per cycle, after three head reads, and then drains the MAC
// pipe. An excite reads the row, then writes it back.
// After reset a clearing pass over all MAX_POINTS rows zeroes the grid; req
// stalls during it. A step result waits in the rsp register while the
// next beat is accepted; a step only finishes once that register is free.
module stiff_bar_free_end_stencil #(
   parameter int MAX_POINTS = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [6:0]                req_point_index,
   input  sbs_pkg::word_type         req_excite_amount,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sbs_pkg::word_type         rsp_displacement,
   output logic                      rsp_saturated,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [sbs_pkg::CSR_W-1:0] csr_index,
   input  sbs_pkg::word_type         csr_data
);
   import sbs_pkg::*;

   localparam int ADDR_W    = $clog2(MAX_POINTS);
   localparam int SEQ_W     = $clog2(MAX_POINTS + 8);
   localparam int LAST      = MAX_POINTS - 1;
   localparam int HEAD_ROWS = 3;
   localparam int SEQ_VL2   = 3;
   localparam int SEQ_VL1   = 4;
   localparam int SEQ_REAL0 = 5;
   localparam int WIN_FILL  = 4;

   // configuration
   word_type          coef_center_ff, coef_near_ff, coef_far_ff;
   word_type          coef_prev_center_ff, coef_prev_near_ff;
   logic [GRID_W-1:0] grid_last_ff, listen_ff;

   state_type         state_ff, state_in;
   logic [1:0]        rot_ff;
   logic [1:0]        ln_cur, ln_prv;
   logic [ADDR_W-1:0] n_eff, li_eff;
   logic              pi_ok;
   logic [ADDR_W-1:0] clr_ff;
   logic [SEQ_W-1:0]  seq_ff, seq_rend;
   tag_type           tag_ff, issue_tag;
   logic [1:0]        tag_head_ff;
   logic [ADDR_W-1:0] issue_addr, exc_addr_ff;
   word_type          exc_amt_ff;
   logic              sat_ff;
   word_type          listen_val_ff;

   // memory ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [ROW_W-1:0]  wr_data, rd_data;

   // window and boundary registers
   word_type          hc_ff [3], hp_ff [3], tc_ff [3], tp_ff [3];
   word_type          wc_ff [5], wp_ff [3];
   word_type          wp_hold_ff;
   logic [2:0]        pcnt_ff;
   logic [ADDR_W-1:0] pt_ff, win_pt_ff;
   pt_ctl_type        win_ctl_ff;
   logic              push, push_flag;
   word_type          push_c, push_p, rd_cur, rd_prv, rd_nxt;
   logic signed [VIRT_W-1:0] vc, vp;

   // MAC results
   pt_ctl_type        res_ctl;
   logic [ADDR_W-1:0] res_pt;
   word_type          res_value, res_cur, res_prv;
   logic              res_sat;

   logic              step_go, exc_go, out_free;
   logic signed [VIRT_W-1:0] exc_c, exc_p;
   logic              rsp_valid_ff;
   word_type          rsp_disp_ff;
   logic              rsp_sat_ff;

   function automatic word_type lane_of(input logic [ROW_W-1:0] row,
                                        input logic [1:0] idx);
      case (idx)
         2'd0:    return row[0*DATA_W +: DATA_W];
         2'd1:    return row[1*DATA_W +: DATA_W];
         2'd2:    return row[2*DATA_W +: DATA_W];
         default: return '0;
      endcase
   endfunction

   // effective grid, listen point and excite range
   always_comb begin
      if (int'(grid_last_ff) > LAST) n_eff = ADDR_W'(LAST);
      else if (int'(grid_last_ff) < MIN_LAST) n_eff = ADDR_W'(MIN_LAST);
      else n_eff = ADDR_W'(grid_last_ff);
      if (int'(listen_ff) > int'(n_eff)) li_eff = n_eff;
      else li_eff = ADDR_W'(listen_ff);
      pi_ok = int'(req_point_index) <= int'(n_eff);
   end

   // lane roles: rot_ff is next, then current, then previous
   always_comb begin
      ln_cur = (rot_ff == 2'd2) ? 2'd0 : rot_ff + 2'd1;
      ln_prv = (rot_ff == 2'd0) ? 2'd2 : rot_ff - 2'd1;
      rd_nxt = lane_of(rd_data, rot_ff);
      rd_cur = lane_of(rd_data, ln_cur);
      rd_prv = lane_of(rd_data, ln_prv);
   end

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_center_ff      <= '0;
         coef_near_ff        <= '0;
         coef_far_ff         <= '0;
         coef_prev_center_ff <= '0;
         coef_prev_near_ff   <= '0;
         grid_last_ff        <= GRID_W'(32);
         listen_ff           <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_type'(csr_index))
            CSR_COEF_CENTER:      coef_center_ff      <= csr_data;
            CSR_COEF_NEAR:        coef_near_ff        <= csr_data;
            CSR_COEF_FAR:         coef_far_ff         <= csr_data;
            CSR_COEF_PREV_CENTER: coef_prev_center_ff <= csr_data;
            CSR_COEF_PREV_NEAR:   coef_prev_near_ff   <= csr_data;
            CSR_GRID_LAST:        grid_last_ff        <= csr_data[GRID_W-1:0];
            CSR_LISTEN_INDEX:     listen_ff           <= csr_data[GRID_W-1:0];
            default: ;
         endcase
      end
   end

   // sweep read order: three head rows, two left virtuals, rows 0 to n_eff, two right
   always_comb begin
      seq_rend   = SEQ_W'(n_eff) + SEQ_W'(SEQ_REAL0);
      issue_tag  = TAG_NONE;
      issue_addr = '0;
      if (state_ff == ST_SWEEP && seq_ff <= seq_rend + SEQ_W'(2)) begin
         if (seq_ff < SEQ_W'(HEAD_ROWS)) begin
            issue_tag  = TAG_HEAD;
            issue_addr = ADDR_W'(seq_ff);
         end else if (seq_ff == SEQ_W'(SEQ_VL2)) begin
            issue_tag = TAG_VL2;
         end else if (seq_ff == SEQ_W'(SEQ_VL1)) begin
            issue_tag = TAG_VL1;
         end else if (seq_ff <= seq_rend) begin
            issue_tag  = TAG_REAL;
            issue_addr = ADDR_W'(seq_ff - SEQ_W'(SEQ_REAL0));
         end else if (seq_ff == seq_rend + SEQ_W'(1)) begin
            issue_tag = TAG_VR1;
         end else begin
            issue_tag = TAG_VR2;
         end
      end
   end

   // value pushed into the stencil window this cycle
   always_comb begin
      push      = 1'b1;
      push_flag = 1'b0;
      push_c    = rd_cur;
      push_p    = rd_prv;
      vc        = '0;
      vp        = '0;
      case (tag_ff)
         TAG_REAL: ;
         TAG_VL2: begin
            vc        = quad_ext(hc_ff[0], hc_ff[1], hc_ff[2]);
            push_c    = sat_word(vc);
            push_p    = '0;
            push_flag = sat_hit(vc);
         end
         TAG_VL1: begin
            vc        = lin_ext(hc_ff[0], hc_ff[1]);
            vp        = lin_ext(hp_ff[0], hp_ff[1]);
            push_c    = sat_word(vc);
            push_p    = sat_word(vp);
            push_flag = sat_hit(vc) || sat_hit(vp);
         end
         TAG_VR1: begin
            vc        = lin_ext(tc_ff[0], tc_ff[1]);
            vp        = lin_ext(tp_ff[0], tp_ff[1]);
            push_c    = sat_word(vc);
            push_p    = sat_word(vp);
            push_flag = sat_hit(vc) || sat_hit(vp);
         end
         TAG_VR2: begin
            vc        = quad_ext(tc_ff[0], tc_ff[1], tc_ff[2]);
            push_c    = sat_word(vc);
            push_p    = '0;
            push_flag = sat_hit(vc);
         end
         default: push = 1'b0;
      endcase
   end

   // read tag, head and tail capture, stencil window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff           <= TAG_NONE;
         win_ctl_ff.valid <= 1'b0;
         pcnt_ff          <= '0;
      end else begin
         tag_ff           <= issue_tag;
         win_ctl_ff.valid <= push && (pcnt_ff == 3'(WIN_FILL));
         if (step_go) begin
            pcnt_ff <= '0;
         end else if (push && pcnt_ff != 3'(WIN_FILL)) begin
            pcnt_ff <= pcnt_ff + 3'd1;
         end
      end
      tag_head_ff       <= issue_addr[1:0];
      win_ctl_ff.listen <= pt_ff == li_eff;
      win_ctl_ff.last   <= pt_ff == n_eff;
      win_pt_ff         <= pt_ff;
      if (step_go) begin
         pt_ff <= '0;
      end else if (push && pcnt_ff == 3'(WIN_FILL)) begin
         pt_ff <= pt_ff + ADDR_W'(1);
      end
      if (tag_ff == TAG_HEAD) begin
         hc_ff[tag_head_ff] <= rd_cur;
         hp_ff[tag_head_ff] <= rd_prv;
      end
      if (tag_ff == TAG_REAL) begin
         tc_ff[0] <= rd_cur;
         tp_ff[0] <= rd_prv;
         for (int i = 1; i < 3; i++) begin
            tc_ff[i] <= tc_ff[i-1];
            tp_ff[i] <= tp_ff[i-1];
         end
      end
      if (push) begin
         for (int i = 0; i < 4; i++) wc_ff[i] <= wc_ff[i+1];
         wc_ff[4] <= push_c;
         // previous values lag by one push so that wp_ff centers on wc_ff[2]
         wp_hold_ff <= push_p;
         wp_ff[0]   <= wp_ff[1];
         wp_ff[1]   <= wp_ff[2];
         wp_ff[2]   <= wp_hold_ff;
      end
   end

   sbs_mac #(.PT_W(ADDR_W)) u_mac (
      .clock            (clock),
      .reset            (reset),
      .in_ctl           (win_ctl_ff),
      .in_pt            (win_pt_ff),
      .cur_tap          (wc_ff),
      .prv_tap          (wp_ff),
      .coef_center      (coef_center_ff),
      .coef_near        (coef_near_ff),
      .coef_far         (coef_far_ff),
      .coef_prev_center (coef_prev_center_ff),
      .coef_prev_near   (coef_prev_near_ff),
      .res_ctl          (res_ctl),
      .res_pt           (res_pt),
      .res_value        (res_value),
      .res_sat          (res_sat),
      .res_cur          (res_cur),
      .res_prv          (res_prv)
   );

   // control state machine and memory port steering
   always_comb begin
      state_in  = state_ff;
      req_stall = state_ff != ST_IDLE;
      step_go   = 1'b0;
      exc_go    = 1'b0;
      out_free  = !rsp_valid_ff || !rsp_stall;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = issue_addr;
      exc_c     = VIRT_W'(rd_cur) + VIRT_W'(exc_amt_ff);
      exc_p     = VIRT_W'(rd_prv) + VIRT_W'(exc_amt_ff);
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == ADDR_W'(LAST)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            rd_addr = ADDR_W'(req_point_index);
            if (req_valid) begin
               if (!req_kind) begin
                  step_go  = 1'b1;
                  state_in = ST_SWEEP;
               end else if (pi_ok) begin
                  exc_go   = 1'b1;
                  state_in = ST_EXCITE;
               end
            end
         end
         ST_EXCITE: begin
            wr_en   = 1'b1;
            wr_addr = exc_addr_ff;
            for (int i = 0; i < LANES; i++) begin
               if (2'(i) == ln_cur) wr_data[i*DATA_W +: DATA_W] = sat_word(exc_c);
               else if (2'(i) == ln_prv) wr_data[i*DATA_W +: DATA_W] = sat_word(exc_p);
               else wr_data[i*DATA_W +: DATA_W] = rd_nxt;
            end
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            wr_en   = res_ctl.valid;
            wr_addr = res_pt;
            for (int i = 0; i < LANES; i++) begin
               if (2'(i) == rot_ff) wr_data[i*DATA_W +: DATA_W] = res_value;
               else if (2'(i) == ln_cur) wr_data[i*DATA_W +: DATA_W] = res_cur;
               else wr_data[i*DATA_W +: DATA_W] = res_prv;
            end
            if (res_ctl.valid && res_ctl.last) state_in = ST_PUT;
         end
         ST_PUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rot_ff   <= '0;
         seq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + ADDR_W'(1);
         if (step_go) seq_ff <= '0;
         else if (issue_tag != TAG_NONE) seq_ff <= seq_ff + SEQ_W'(1);
         // next becomes current, current becomes previous
         if (state_ff == ST_SWEEP && state_in == ST_PUT) rot_ff <= ln_prv;
      end
      if (exc_go) begin
         exc_addr_ff <= ADDR_W'(req_point_index);
         exc_amt_ff  <= req_excite_amount;
      end
      if (step_go) sat_ff <= 1'b0;
      else if (state_ff == ST_SWEEP) begin
         sat_ff <= sat_ff || push_flag || (res_ctl.valid && res_sat);
      end
      if (res_ctl.valid && res_ctl.listen) listen_val_ff <= res_value;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_PUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_PUT && out_free) begin
         rsp_disp_ff <= listen_val_ff;
         rsp_sat_ff  <= sat_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_displacement = rsp_disp_ff;
   assign rsp_saturated    = rsp_sat_ff;

   sbs_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );
endmodule

### src/sbs_checker.sv
// Port-level checks for the stiff bar block, bound to its top level.
// Depends on sbs_pkg and stiff_bar_free_end_stencil.
module sbs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_kind,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sbs_pkg::word_type rsp_displacement,
   input logic              csr_ready
);
   // the grid clear follows reset, so no beat is taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("req taken right after reset");

   // a step keeps the block busy on the next cycle
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_kind) |=> req_stall)
      else $error("step accepted but block not busy");

   // an excite never produces a result beat
   a_excite_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind && !rsp_valid) |=> !rsp_valid)
      else $error("excite produced a result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_displacement)))
      else $error("stalled result changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr not ready");
endmodule

bind stiff_bar_free_end_stencil sbs_checker u_sbs_checker (.*);
